// ----- hdl/nrd_pkg.sv -----
package nrd_pkg;

    localparam int unsigned W_IN   = 16;
    localparam int unsigned W_QUOT = 17;
    localparam int unsigned W_NSH  = 32;
    localparam int unsigned W_REC  = 32;

    localparam logic [W_QUOT-1:0] QUOT_MAX = 17'h1ffff;

    localparam logic [7:0] SEED_ROM [0:256] = '{
        8'hff, 8'hfd, 8'hfb, 8'hf9, 8'hf7, 8'hf5, 8'hf3, 8'hf1,
        8'hef, 8'hee, 8'hec, 8'hea, 8'he8, 8'he6, 8'he4, 8'he3,
        8'he1, 8'hdf, 8'hdd, 8'hdc, 8'hda, 8'hd8, 8'hd6, 8'hd5,
        8'hd3, 8'hd1, 8'hd0, 8'hce, 8'hcd, 8'hcb, 8'hc9, 8'hc8,
        8'hc6, 8'hc5, 8'hc3, 8'hc1, 8'hc0, 8'hbe, 8'hbd, 8'hbb,
        8'hba, 8'hb8, 8'hb7, 8'hb5, 8'hb4, 8'hb2, 8'hb1, 8'hb0,
        8'hae, 8'had, 8'hab, 8'haa, 8'ha9, 8'ha7, 8'ha6, 8'ha4,
        8'ha3, 8'ha2, 8'ha0, 8'h9f, 8'h9e, 8'h9c, 8'h9b, 8'h9a,
        8'h99, 8'h97, 8'h96, 8'h95, 8'h94, 8'h92, 8'h91, 8'h90,
        8'h8f, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h87, 8'h86,
        8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h7f, 8'h7e, 8'h7d,
        8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h75, 8'h74,
        8'h73, 8'h72, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c,
        8'h6b, 8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64,
        8'h63, 8'h62, 8'h61, 8'h60, 8'h5f, 8'h5e, 8'h5d, 8'h5d,
        8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55,
        8'h54, 8'h53, 8'h53, 8'h52, 8'h51, 8'h50, 8'h4f, 8'h4e,
        8'h4d, 8'h4d, 8'h4c, 8'h4b, 8'h4a, 8'h49, 8'h48, 8'h48,
        8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h43, 8'h42, 8'h41,
        8'h40, 8'h3f, 8'h3f, 8'h3e, 8'h3d, 8'h3c, 8'h3c, 8'h3b,
        8'h3a, 8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h36, 8'h35,
        8'h34, 8'h33, 8'h33, 8'h32, 8'h31, 8'h31, 8'h30, 8'h2f,
        8'h2e, 8'h2e, 8'h2d, 8'h2c, 8'h2c, 8'h2b, 8'h2a, 8'h2a,
        8'h29, 8'h28, 8'h28, 8'h27, 8'h26, 8'h26, 8'h25, 8'h24,
        8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h20, 8'h20, 8'h1f,
        8'h1e, 8'h1e, 8'h1d, 8'h1d, 8'h1c, 8'h1b, 8'h1b, 8'h1a,
        8'h19, 8'h19, 8'h18, 8'h18, 8'h17, 8'h16, 8'h16, 8'h15,
        8'h15, 8'h14, 8'h14, 8'h13, 8'h12, 8'h12, 8'h11, 8'h11,
        8'h10, 8'h0f, 8'h0f, 8'h0e, 8'h0e, 8'h0d, 8'h0d, 8'h0c,
        8'h0c, 8'h0b, 8'h0a, 8'h0a, 8'h09, 8'h09, 8'h08, 8'h08,
        8'h07, 8'h07, 8'h06, 8'h06, 8'h05, 8'h05, 8'h04, 8'h04,
        8'h03, 8'h03, 8'h02, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00,
        8'h00
    };

    // Leading zeros of a 16-bit value; 16 for zero.
    function automatic logic [4:0] lead_zeros16(input logic [15:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd16;
        found = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(15 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/nrd_if.sv -----
interface nrd_in_if import nrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_IN-1:0]   numerator;
    logic [W_IN-1:0]   divisor;
    modport source (output valid, output numerator, output divisor, input ready);
    modport sink   (input valid, input numerator, input divisor, output ready);
endinterface

interface nrd_out_if import nrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_QUOT-1:0] quotient;
    modport source (output valid, output quotient, input ready);
    modport sink   (input valid, input quotient, output ready);
endinterface

// ----- hdl/nrd_recip.sv -----
// Reciprocal datapath: normalize, seed lookup, Newton-Raphson step.
// Four register stages, all advancing on i_en.
module nrd_recip import nrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_IN-1:0]   i_num,
    input  logic [W_IN-1:0]   i_div,
    output logic [W_NSH-1:0]  o_nsh,
    output logic [W_REC-1:0]  o_rec
);

    // Stage 1: normalize both operands.
    logic [4:0]        n_sh;
    logic [W_NSH-1:0]  r_nsh1;
    logic [15:0]       r_dn1;
    assign n_sh = lead_zeros16(i_div);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsh1 <= {16'd0, i_num} << n_sh;
            r_dn1  <= 16'(i_div << n_sh);
        end
    end

    // Stage 2: seed lookup and first product ds * f.
    // The seed plus 0x101 reaches 0x200, so f needs ten bits.
    logic [8:0]        n_idx;
    logic [9:0]        n_f;
    logic [16:0]       n_sum;
    logic [W_NSH-1:0]  r_nsh2;
    logic [9:0]        r_f2;
    logic [24:0]       r_p2;
    assign n_sum = {2'b00, r_dn1[14:0]} + 17'h40;
    assign n_idx = n_sum[15:7];
    assign n_f   = {2'b00, SEED_ROM[n_idx]} + 10'h101;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsh2 <= r_nsh1;
            r_f2   <= n_f;
            r_p2   <= 25'({r_dn1 | 16'h8000} * n_f);
        end
    end

    // Stage 3: inner = 0x20000 + floor((0x80 - p) / 256).
    logic signed [26:0] n_t3;
    logic signed [26:0] n_inner;
    logic [W_NSH-1:0]   r_nsh3;
    logic [9:0]         r_f3;
    logic signed [26:0] r_inner3;
    assign n_t3    = 27'sh80 - $signed({2'b00, r_p2});
    assign n_inner = 27'sh20000 + (n_t3 >>> 8);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsh3   <= r_nsh2;
            r_f3     <= r_f2;
            r_inner3 <= n_inner;
        end
    end

    // Stage 4: r = floor((f * inner + 0x80) / 256).
    logic signed [37:0] n_p4;
    logic signed [37:0] n_r4;
    logic [W_NSH-1:0]   r_nsh4;
    logic [W_REC-1:0]   r_rec4;
    assign n_p4 = $signed({28'd0, r_f3}) * 38'(r_inner3) + 38'sh80;
    assign n_r4 = n_p4 >>> 8;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nsh4 <= r_nsh3;
            r_rec4 <= n_r4[W_REC-1:0];
        end
    end

    assign o_nsh = r_nsh4;
    assign o_rec = r_rec4;

endmodule

// ----- hdl/nrd_quot.sv -----
// Final multiply split in two 32x16 partial products, then round and saturate.
module nrd_quot import nrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_NSH-1:0]  i_nsh,
    input  logic [W_REC-1:0]  i_rec,
    output logic [W_QUOT-1:0] o_quot
);

    // Stage 5: partial products on the low and high numerator halves.
    logic [47:0] r_plo;
    logic [47:0] r_phi;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= 48'(i_rec * i_nsh[15:0]);
            r_phi <= 48'(i_rec * i_nsh[31:16]);
        end
    end

    // Stage 6: sum modulo 2^64, round, shift and saturate.
    logic [63:0] n_prod;
    logic [63:0] n_q;
    logic [W_QUOT-1:0] r_q;
    assign n_prod = {16'd0, r_plo} + {r_phi, 16'd0} + 64'h8000;
    assign n_q    = n_prod >> 16;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= (n_q > 64'(QUOT_MAX)) ? QUOT_MAX : n_q[W_QUOT-1:0];
        end
    end

    assign o_quot = r_q;

endmodule

// ----- hdl/newton_raphson_reciprocal_divider_unit.sv -----
// Unsigned 16-bit divider, numerator / divisor in unsigned 1.16 fixed point.
// Input channel i_in carries numerator and divisor; output channel o_out
// carries the 17-bit quotient, saturated at 0x1ffff. A zero divisor gives
// 0 for a zero numerator and 0x1ffff otherwise.
// Beats are taken on valid and ready both high.
// Each beat passes through every stage to the output valid; the pipeline
// takes one beat every cycle unless the receiver stalls. Its depth is set
// by the normalize, seed lookup, two Newton-Raphson multiply stages and
// the final product, which is split into two partial-product stages.
// The whole pipeline advances together: when the receiver stalls with the
// last stage full, every stage holds and i_in.ready drops, so nothing is
// lost or repeated. Bubbles travel with the pipeline and are not squeezed
// out; the input is held off whenever the last stage waits on the receiver.
// Reset clears the stage valid bits only; the datapath is not reset.
module newton_raphson_reciprocal_divider_unit import nrd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nrd_in_if.sink    i_in,
    nrd_out_if.source o_out
);

    localparam int unsigned N_STG = 6;

    logic [N_STG-1:0] r_vld;
    logic             n_en;
    logic [W_NSH-1:0] w_nsh;
    logic [W_REC-1:0] w_rec;

    // The pipeline moves when the last stage is empty or being drained.
    assign n_en       = !r_vld[N_STG-1] || o_out.ready;
    assign i_in.ready = n_en;

    // Valid bits shift along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_in.valid};
        end
    end

    nrd_recip u_recip (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (i_in.numerator),
        .i_div (i_in.divisor),
        .o_nsh (w_nsh),
        .o_rec (w_rec)
    );

    nrd_quot u_quot (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_nsh  (w_nsh),
        .i_rec  (w_rec),
        .o_quot (o_out.quotient)
    );

    assign o_out.valid = r_vld[N_STG-1];

endmodule
